// File: rtl/stream_duplicate_filter_defines.svh
// Assertion macros used by the duplicate filter top level
`ifndef STREAM_DUPLICATE_FILTER_DEFINES_SVH
`define STREAM_DUPLICATE_FILTER_DEFINES_SVH

// check that cons holds in the same cycle as ante
`define SDF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that cons holds in the cycle after ante
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sdf_pkg.sv
// Package with sizes and types of the duplicate filter
`default_nettype none
package sdf_pkg;
	localparam int CAPACITY  = 64;
	localparam int KEY_WIDTH = 32;
	localparam int DATA_W    = 32;
	localparam int CMP_W     = (KEY_WIDTH < DATA_W) ? KEY_WIDTH : DATA_W;
	localparam int FILL_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              ovf;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} push_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
	} front_stat_t;
endpackage
`default_nettype wire

// File: rtl/sdf_front.sv
// Front part: seen-table lookup, insert and classification of each key
`default_nettype none
module sdf_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [sdf_pkg::DATA_W-1:0] in_key,
	input  wire logic                  in_eos,
	input  wire logic                  q_ready,
	output sdf_pkg::push_t             push,
	output sdf_pkg::front_stat_t       stat
);
	import sdf_pkg::*;

	logic [CMP_W-1:0]  keys_q [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CAPACITY-1:0] match;
	logic [FILL_W-1:0] fill_q;
	logic [CMP_W-1:0]  key;
	logic              hit;
	logic              full;
	logic              accept;
	logic              ins;

	assign key = in_key[CMP_W-1:0];

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
		assign match[g] = valid_q[g] && (keys_q[g] == key);
	end

	assign hit      = |match;
	assign full     = (fill_q == FILL_W'(CAPACITY));
	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;
	assign ins      = accept && !hit && !full;

	assign push.valid     = accept && !hit;
	assign push.res.value = DATA_W'(key);
	assign push.res.ovf   = full;

	assign stat.fill = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			valid_q <= '0;
		end else if (accept && in_eos) begin
			fill_q  <= '0;
			valid_q <= '0;
		end else if (ins) begin
			fill_q  <= fill_q + FILL_W'(1);
			valid_q[fill_q[IDX_W-1:0]] <= 1'b1;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_store
		always_ff @(posedge clk) begin
			if (ins && (fill_q[IDX_W-1:0] == IDX_W'(g))) begin
				keys_q[g] <= key;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/sdf_queue.sv
// Back part: short result queue that drives the output stream
`default_nettype none
module sdf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sdf_pkg::push_t  push,
	output logic                 push_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sdf_pkg::result_t     out_res
);
	import sdf_pkg::*;

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign out_valid  = (cnt_q != '0);
	assign out_res    = mem_q[rd_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.res;
		end
	end
endmodule
`default_nettype wire

// File: rtl/stream_duplicate_filter.sv
// Top level of the stream duplicate filter
// Passes on only the first occurrence of each key in the input stream, in order,
// and drops repeats. A 64-entry seen-table is searched in full every cycle and a
// new key is stored in the same cycle, so one beat is taken per clock with no
// bubbles while the queue has room; each result is registered in the queue. A new
// key that finds the table full is still passed on, with tuser set, but is not
// stored. A beat with tlast clears the table after that beat has been handled.
// A four-entry result queue decouples the output: input stalls only while it is full.
`default_nettype none
`include "stream_duplicate_filter_defines.svh"
module stream_duplicate_filter (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire logic [sdf_pkg::DATA_W-1:0] s_axis_tdata,  // key_value
	input  wire logic                       s_axis_tlast,  // end_of_stream
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output logic [sdf_pkg::DATA_W-1:0]      m_axis_tdata,  // unique_value
	output logic                            m_axis_tuser   // table_overflow
);
	import sdf_pkg::*;

	push_t       push;
	front_stat_t stat;
	result_t     out_res;
	logic        q_ready;

	sdf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_key   (s_axis_tdata),
		.in_eos   (s_axis_tlast),
		.q_ready  (q_ready),
		.push     (push),
		.stat     (stat)
	);

	sdf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (q_ready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = out_res.value;
	assign m_axis_tuser = out_res.ovf;

	`SDF_ASSERT_SAME(a_push_room, push.valid, q_ready, "result pushed into a full queue")
	`SDF_ASSERT_SAME(a_fill_range, 1'b1, stat.fill <= FILL_W'(CAPACITY), "fill count past capacity")
	`SDF_ASSERT_SAME(a_ovf_full, push.valid && push.res.ovf, stat.fill == FILL_W'(CAPACITY),
		"overflow flagged on a table that is not full")
	`SDF_ASSERT_NEXT(a_eos_clear, s_axis_tvalid && s_axis_tready && s_axis_tlast,
		stat.fill == '0, "table not cleared after last beat")
endmodule
`default_nettype wire
